// ===== rtl/qknob_pkg.sv =====
// ---------------------------------------------------------------------------
// qknob_pkg
// Shared types, constants and the quadrature transition table for the knob.
// ---------------------------------------------------------------------------
package qknob_pkg;

  // Default width of the button hold counter
  localparam int HOLD_COUNT_BITS_DEF = 16;

  // Configuration register map
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_LONG_PRESS_POLLS = 1'b0;  // index of long_press_polls
  localparam logic [15:0] LONG_PRESS_POLLS_RST = 16'd2000;

  // Counts per detent
  localparam logic signed [3:0] DETENT_POS = 4'sd4;
  localparam logic signed [3:0] DETENT_NEG = -4'sd4;

  // Step codes on rotate_step
  localparam logic signed [1:0] STEP_NONE = 2'sd0;
  localparam logic signed [1:0] STEP_CW   = 2'sd1;
  localparam logic signed [1:0] STEP_CCW  = -2'sd1;

  // Button events from one poll
  typedef struct packed {
    logic short_press;
    logic long_press;
  } btn_evt_t;

  // Transition table: index is {prev_b, prev_a, cur_b, cur_a}
  function automatic logic signed [1:0] step_lut(input logic [3:0] idx);
    logic signed [1:0] s;
    case (idx)
      4'h1, 4'h7, 4'h8, 4'hE: s = STEP_CCW;
      4'h2, 4'h4, 4'hB, 4'hD: s = STEP_CW;
      default:                s = STEP_NONE;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/quadrature_knob_with_long_press.sv =====
// ---------------------------------------------------------------------------
// quadrature_knob_with_long_press
// Rotary knob poll decoder: detent steps plus short and long button presses.
// ---------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  in       | in_valid / in_ready  | phase_a, phase_b, switch_line
//  out      | out_valid / out_ready| rotate_step, short_press, long_press
//  cfg      | APB psel/penable     | long_press_polls at byte address 0
//
//  One item per cycle sustained while out_ready is high; each item passes the
//  input register, then decode logic into the result register.
//  Knob and button state advance when an item moves from the input register
//  into the result register.
//  A stalled result holds the input register; in_ready drops only then.
//  Reset (rst, synchronous) clears the valid flags and the knob and button state; long_press_polls returns to 2000.
// ---------------------------------------------------------------------------
module quadrature_knob_with_long_press #(
  parameter int HOLD_COUNT_BITS = qknob_pkg::HOLD_COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // input items
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             phase_a,
  input  logic                             phase_b,
  input  logic                             switch_line,
  // result items
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [1:0]                rotate_step,
  output logic                             short_press,
  output logic                             long_press,
  // configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [qknob_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [qknob_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [qknob_pkg::CFG_DATA_W-1:0] prdata,
  output logic                             pready
);
  import qknob_pkg::*;

  logic              s1_valid;
  logic              s1_a;
  logic              s1_b;
  logic              s1_sw;
  logic              adv;
  logic [15:0]       long_press_polls;
  logic signed [1:0] step;
  btn_evt_t          evt;

  // Config register
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_polls <= LONG_PRESS_POLLS_RST;
    end else if (psel && penable && pwrite && (paddr[2] == REG_LONG_PRESS_POLLS)) begin
      long_press_polls <= pwdata[15:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_LONG_PRESS_POLLS) begin
      prdata = {{(CFG_DATA_W-16){1'b0}}, long_press_polls};
    end
  end

  // Handshake: input register advances when the result register is free
  assign adv      = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || adv;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_a  <= phase_a;
      s1_b  <= phase_b;
      s1_sw <= switch_line;
    end
  end

  // Decode units
  qknob_rot u_rot (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .phase_a (s1_a),
    .phase_b (s1_b),
    .step    (step)
  );

  qknob_btn #(
    .HOLD_COUNT_BITS (HOLD_COUNT_BITS)
  ) u_btn (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .switch_line (s1_sw),
    .threshold   (long_press_polls),
    .evt         (evt)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rotate_step <= step;
      short_press <= evt.short_press;
      long_press  <= evt.long_press;
    end
  end

`ifndef SYNTHESIS
  // Only -1, 0 or +1 ever leaves the block
  a_step_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (rotate_step != 2'b10))
    else $error("rotate_step holds an illegal code");

  // One button event per poll at most
  a_evt_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(short_press && long_press))
    else $error("short and long press in the same item");

  // A stalled result keeps a waiting item in the input register
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !out_ready) |=> s1_valid)
    else $error("input item lost under stall");

  // Every advance produces a result
  a_adv_out: assert property (@(posedge clk) disable iff (rst)
    adv |=> out_valid)
    else $error("advance without result");
`endif

endmodule

// ===== rtl/qknob_rot.sv =====
// ---------------------------------------------------------------------------
// qknob_rot
// Quadrature decode: phase history, transition table, detent accumulator.
// ---------------------------------------------------------------------------
module qknob_rot (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   adv,
  input  logic                   phase_a,
  input  logic                   phase_b,
  output logic signed [1:0]      step
);
  import qknob_pkg::*;

  logic [3:0]        hist;
  logic [3:0]        hist_next;
  logic signed [3:0] acc;
  logic signed [3:0] acc_next;
  logic signed [1:0] delta;
  logic signed [3:0] sum;

  // Table lookup and detent check
  always_comb begin
    hist_next = {hist[1:0], phase_b, phase_a};
    delta     = step_lut(hist_next);
    sum       = acc + {{2{delta[1]}}, delta};
    step      = STEP_NONE;
    acc_next  = sum;
    if (sum >= DETENT_POS) begin
      acc_next = sum - DETENT_POS;
      step     = STEP_CW;
    end else if (sum <= DETENT_NEG) begin
      acc_next = sum - DETENT_NEG;
      step     = STEP_CCW;
    end
  end

  // State update once per item
  always_ff @(posedge clk) begin
    if (rst) begin
      hist <= '0;
      acc  <= '0;
    end else if (adv) begin
      hist <= hist_next;
      acc  <= acc_next;
    end
  end

endmodule

// ===== rtl/qknob_btn.sv =====
// ---------------------------------------------------------------------------
// qknob_btn
// Push button: press edge, saturating hold counter, short/long press events.
// ---------------------------------------------------------------------------
module qknob_btn #(
  parameter int HOLD_COUNT_BITS = qknob_pkg::HOLD_COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                switch_line,
  input  logic [15:0]         threshold,
  output qknob_pkg::btn_evt_t evt
);
  import qknob_pkg::*;

  localparam int CMP_W = (HOLD_COUNT_BITS > 16) ? HOLD_COUNT_BITS : 16;

  logic                       held;
  logic                       held_next;
  logic                       done;
  logic                       done_next;
  logic [HOLD_COUNT_BITS-1:0] cnt;
  logic [HOLD_COUNT_BITS-1:0] cnt_next;
  logic [HOLD_COUNT_BITS-1:0] cnt_inc;
  logic                       down;

  // Event and next-state logic
  always_comb begin
    down      = ~switch_line;
    cnt_inc   = (&cnt) ? cnt : cnt + 1'b1;
    held_next = held;
    done_next = done;
    cnt_next  = cnt;
    evt       = '0;
    if (down && !held) begin
      held_next = 1'b1;
      done_next = 1'b0;
      cnt_next  = '0;
    end else if (down && held && !done) begin
      cnt_next = cnt_inc;
      if (CMP_W'(cnt_inc) >= CMP_W'(threshold)) begin
        done_next      = 1'b1;
        evt.long_press = 1'b1;
      end
    end else if (!down && held) begin
      held_next       = 1'b0;
      evt.short_press = ~done;
    end
  end

  // State update once per item
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (adv) begin
      held <= held_next;
      done <= done_next;
      cnt  <= cnt_next;
    end
  end

endmodule
